>>> hdl/b64le_pkg.sv
`default_nettype none

package b64le_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  localparam logic [6:0] CharCr  = 7'd13;
  localparam logic [6:0] CharLf  = 7'd10;
  localparam logic [6:0] CharPad = 7'd61;

  localparam logic [2:0] PosCr = 3'd0;
  localparam logic [2:0] PosLf = 3'd1;
  localparam logic [2:0] PosS0 = 3'd2;
  localparam logic [2:0] PosS1 = 3'd3;
  localparam logic [2:0] PosS2 = 3'd4;
  localparam logic [2:0] PosS3 = 3'd5;

  typedef struct packed {
    logic [23:0] group;
    logic [1:0]  n_held;
    logic        brk;
  } cmd_t;

  function automatic logic [6:0] b64_sym(input logic [5:0] v);
    logic [6:0] w;
    w = {1'b0, v};
    priority if (v < 6'd26) return w + 7'd65;
    else if (v < 6'd52) return w + 7'd71;
    else if (v < 6'd62) return w - 7'd4;
    else if (v == 6'd62) return 7'd43;
    else return 7'd47;
  endfunction

endpackage

`default_nettype wire

>>> hdl/b64le_if.sv
`default_nettype none

interface b64le_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;
  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64le_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last_of_run;
  modport source (output valid, output char_code, output last_of_run, input ready);
  modport sink (input valid, input char_code, input last_of_run, output ready);
endinterface

interface b64le_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] line_length;
  modport source (output valid, output line_length, input ready);
  modport sink (input valid, input line_length, output ready);
endinterface

`default_nettype wire

>>> hdl/b64le_front.sv
`default_nettype none

module b64le_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  b64le_in_if.sink           in_i,
  input  wire logic [15:0]   line_length_i,
  output b64le_pkg::cmd_t    cmd_o,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i
);
  import b64le_pkg::*;

  logic [7:0]  held0_q, held0_d, held1_q, held1_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [13:0] gol_q, gol_d;
  logic        accept, closes, brk;

  assign in_i.ready = cmd_ready_i;
  assign accept     = in_i.valid && cmd_ready_i;
  assign closes     = in_i.final_byte || (cnt_q == 2'd2);
  assign brk        = (line_length_i != 16'd0) && (gol_q >= line_length_i[15:2]);
  assign cmd_valid_o = accept && closes;

  always_comb begin
    unique case (cnt_q)
      2'd0:    cmd_o.group = {in_i.data_byte, 16'd0};
      2'd1:    cmd_o.group = {held0_q, in_i.data_byte, 8'd0};
      default: cmd_o.group = {held0_q, held1_q, in_i.data_byte};
    endcase
    cmd_o.n_held = cnt_q;
    cmd_o.brk    = brk;
  end

  always_comb begin
    held0_d = held0_q;
    held1_d = held1_q;
    cnt_d   = cnt_q;
    gol_d   = gol_q;
    if (accept) begin
      if (!closes) begin
        if (cnt_q == 2'd0) begin
          held0_d = in_i.data_byte;
        end else begin
          held1_d = in_i.data_byte;
        end
        cnt_d = cnt_q + 2'd1;
      end else begin
        cnt_d = 2'd0;
        if (in_i.final_byte) begin
          gol_d = 14'd0;
        end else begin
          gol_d = (brk ? 14'd0 : gol_q) + 14'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      gol_q <= 14'd0;
    end else begin
      cnt_q <= cnt_d;
      gol_q <= gol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held0_q <= held0_d;
    held1_q <= held1_d;
  end

endmodule

`default_nettype wire

>>> hdl/b64le_fifo.sv
`default_nettype none

module b64le_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire b64le_pkg::cmd_t push_data_i,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  output b64le_pkg::cmd_t    pop_data_o,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i
);
  import b64le_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCntW'(push) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth)) else $error("queue count beyond depth");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

>>> hdl/b64le_back.sv
`default_nettype none

module b64le_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire b64le_pkg::cmd_t cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  b64le_out_if.source        out_o
);
  import b64le_pkg::*;

  cmd_t       cmd_q, cmd_d;
  logic       busy_q, busy_d;
  logic [2:0] pos_q, pos_d;
  logic       valid_q, valid_d;
  logic [6:0] char_q, char_d;
  logic       last_q, last_d;
  logic       emit, emit_last, pop;
  logic [6:0] cur_char;

  assign emit      = busy_q && (!valid_q || out_o.ready);
  assign emit_last = emit && (pos_q == PosS3);
  assign cmd_ready_o = !busy_q || emit_last;
  assign pop       = cmd_valid_i && cmd_ready_o;

  assign out_o.valid       = valid_q;
  assign out_o.char_code   = char_q;
  assign out_o.last_of_run = last_q;

  always_comb begin
    unique case (pos_q)
      PosCr:   cur_char = CharCr;
      PosLf:   cur_char = CharLf;
      PosS0:   cur_char = b64_sym(cmd_q.group[23:18]);
      PosS1:   cur_char = b64_sym(cmd_q.group[17:12]);
      PosS2:   cur_char = (cmd_q.n_held != 2'd0) ? b64_sym(cmd_q.group[11:6]) : CharPad;
      PosS3:   cur_char = (cmd_q.n_held == 2'd2) ? b64_sym(cmd_q.group[5:0]) : CharPad;
      default: cur_char = CharPad;
    endcase
  end

  always_comb begin
    cmd_d   = cmd_q;
    busy_d  = busy_q;
    pos_d   = pos_q;
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    if (emit) begin
      valid_d = 1'b1;
      char_d  = cur_char;
      last_d  = (pos_q == PosS3);
      pos_d   = pos_q + 3'd1;
      if (pos_q == PosS3) begin
        busy_d = 1'b0;
      end
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
    if (pop) begin
      cmd_d  = cmd_i;
      busy_d = 1'b1;
      pos_d  = cmd_i.brk ? PosCr : PosS0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      pos_q   <= PosCr;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pos_q <= PosS3) else $error("character position out of range");
  a_cr_then_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && pos_q == PosCr) |=> busy_q && pos_q == PosLf) else $error("CR not followed by LF");
  a_last_is_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |-> (char_q != CharCr && char_q != CharLf))
    else $error("line break closes a group");
`endif

endmodule

`default_nettype wire

>>> hdl/base64_line_wrapped_encoder.sv
// A closing transaction's group is written into the queue, then loaded into the back end's
// command register. Characters leave from the output register, one character per cycle while
// out_o.ready is high and a group is queued; a group gives 4 characters, or 6 with CR LF.
// A 2-entry group queue sits between byte intake and character output.
// Reset (rst_ni low, asynchronous) clears held count, group count, queue and line_length.
`default_nettype none

module base64_line_wrapped_encoder (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  b64le_in_if.sink      in_i,
  b64le_cfg_if.sink     cfg_i,
  b64le_out_if.source   out_o
);
  import b64le_pkg::*;

  logic [15:0] line_length_q, line_length_d;
  cmd_t        f_cmd, q_cmd;
  logic        f_valid, f_ready, q_valid, q_ready;

  assign cfg_i.ready   = 1'b1;
  assign line_length_d = cfg_i.valid ? cfg_i.line_length : line_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= 16'd0;
    end else begin
      line_length_q <= line_length_d;
    end
  end

  b64le_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .line_length_i (line_length_q),
    .cmd_o         (f_cmd),
    .cmd_valid_o   (f_valid),
    .cmd_ready_i   (f_ready)
  );

  b64le_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (f_cmd),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_data_o   (q_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready)
  );

  b64le_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_cmd),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

>>> dv/base64_line_wrapped_encoder_test.sv
`timescale 1ns / 1ps

module base64_line_wrapped_encoder_test;
  import b64le_pkg::CharCr;
  import b64le_pkg::CharLf;
  import b64le_pkg::CharPad;

  localparam int HalfPeriod = 4;
  localparam int ResetCycles = 9;
  localparam int SettleCycles = 8;
  localparam int LongHold = 300;
  localparam int WatchdogLimit = 2000;
  localparam logic [511:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_of_run;
  } char_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  b64le_in_if  in_if();
  b64le_out_if out_if();
  b64le_cfg_if cfg_if();

  base64_line_wrapped_encoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always #HalfPeriod clk_i = ~clk_i;

  char_t       expected_chars[$];
  logic [7:0]  held_q[2];
  logic [1:0]  held_n = 2'd0;
  logic [13:0] line_groups = 14'd0;
  logic [15:0] line_len = 16'd0;

  int error_count = 0;
  int bytes_sent = 0;
  int chars_checked = 0;
  int idle_cycles = 0;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_cycles = 0;

  function automatic logic [6:0] b64_char_for(input logic [5:0] v);
    return Alphabet[8 * (63 - int'(v)) +: 7];
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] g0;
    logic [7:0] g1;
    logic [7:0] g2;
    logic [1:0] n;
    logic [6:0] codes[$];
    n = held_n;
    if (!fin && n < 2'd2) begin
      held_q[n] = b;
      held_n = n + 2'd1;
      return;
    end
    g0 = (n == 2'd0) ? b : held_q[0];
    g1 = (n == 2'd0) ? 8'h00 : ((n == 2'd1) ? b : held_q[1]);
    g2 = (n == 2'd2) ? b : 8'h00;
    if (line_len != 16'd0 && {2'b00, line_groups} >= (line_len >> 2)) begin
      codes.push_back(CharCr);
      codes.push_back(CharLf);
      if (!fin) line_groups = 14'd0;
    end
    codes.push_back(b64_char_for(g0[7:2]));
    codes.push_back(b64_char_for({g0[1:0], g1[7:4]}));
    codes.push_back((n != 2'd0) ? b64_char_for({g1[3:0], g2[7:6]}) : CharPad);
    codes.push_back((n == 2'd2) ? b64_char_for(g2[5:0]) : CharPad);
    held_n = 2'd0;
    line_groups = fin ? 14'd0 : line_groups + 14'd1;
    foreach (codes[i]) expected_chars.push_back({codes[i], i == codes.size() - 1});
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99, 0) >= pct) return 0;
    if ($urandom_range(9, 0) == 0) return $urandom_range(60, 20);
    return $urandom_range(4, 1);
  endfunction

  initial begin : receiver
    int stall;
    stall = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        if (stall == 0) stall = pick_gap(rx_stall_pct);
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          stall--;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_chars
    char_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected transaction: char_code %0d, last_of_run %0d",
               out_if.char_code, out_if.last_of_run);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (out_if.char_code !== want.char_code) begin
          $error("char_code: expected %0d, actual %0d", want.char_code, out_if.char_code);
          error_count++;
        end
        if (out_if.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, actual %0d",
                 want.last_of_run, out_if.last_of_run);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap(tx_gap_pct);
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.final_byte <= fin;
    do @(posedge clk_i); while (!in_if.ready);
    encode_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_line_length(input logic [15:0] v);
    wait_for_drain();
    @(negedge clk_i);
    cfg_if.valid       <= 1'b1;
    cfg_if.line_length <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    line_len = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_streams(input int n_items, input int max_run);
    int bytes_left;
    bytes_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (bytes_left == 0) bytes_left = $urandom_range(max_run, 1);
      bytes_left--;
      send_byte(8'($urandom_range(255, 0)), bytes_left == 0);
    end
  endtask

  task automatic test_padding_and_extremes();
    tx_gap_pct = 20;
    rx_stall_pct = 20;
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h4d, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6e, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_short_lines();
    write_line_length(16'd1);
    send_byte(8'haa, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h0f, 1'b0);
    send_byte(8'hf0, 1'b1);
    write_line_length(16'd3);
    send_byte(8'hf0, 1'b0);
    send_byte(8'h0f, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b1);
  endtask

  task automatic test_midstream_change();
    write_line_length(16'd0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    write_line_length(16'd4);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_random_streams();
    logic [15:0] lengths[8];
    int runs[8];
    lengths = '{16'd0, 16'd4, 16'd40, 16'hffff, 16'd2, 16'd5, 16'd24, 16'd0};
    runs = '{12, 12, 90, 12, 6, 20, 60, 30};
    lengths[7] = 16'($urandom_range(64, 4));
    for (int p = 0; p < 8; p++) begin
      write_line_length(lengths[p]);
      tx_gap_pct = (p % 3 == 0) ? 0 : 25;
      rx_stall_pct = (p % 3 == 1) ? 0 : 25;
      send_streams(20, runs[p]);
    end
  endtask

  task automatic test_output_backpressure();
    write_line_length(16'd8);
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    rx_hold_cycles = LongHold;
    send_streams(20, 15);
    wait_for_drain();
    rx_hold_cycles = LongHold;
    send_streams(20, 15);
  endtask

  task automatic test_count_while_disabled();
    write_line_length(16'd0);
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    for (int i = 0; i < 36; i++) send_byte(8'($urandom_range(255, 0)), 1'b0);
    write_line_length(16'd40);
    send_byte(8'h3c, 1'b0);
    send_byte(8'hc3, 1'b0);
    send_byte(8'h7e, 1'b0);
    send_byte(8'h81, 1'b1);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.final_byte = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.line_length = 16'd0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_padding_and_extremes();
    test_short_lines();
    test_midstream_change();
    test_random_streams();
    test_output_backpressure();
    test_count_while_disabled();
    wait_for_drain();

    $display("Sent %0d bytes and checked %0d characters: padding, short and long lines,",
             bytes_sent, chars_checked);
    $display("register changes inside a stream, output stalls and counting with breaks off.");
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> base64_line_wrapped_encoder.f
hdl/b64le_pkg.sv
hdl/b64le_if.sv
hdl/b64le_front.sv
hdl/b64le_fifo.sv
hdl/b64le_back.sv
hdl/base64_line_wrapped_encoder.sv
dv/base64_line_wrapped_encoder_test.sv
